[rtl/core/bdts_pkg.sv]
`timescale 1ns / 1ps

package bdts_pkg;

    // Calendar and clock constants
    localparam logic [7:0] BCD_RADIX     = 8'd10;
    localparam logic [4:0] HOURS_PER_DAY = 5'd24;
    localparam logic [5:0] MINS_PER_HOUR = 6'd60;
    localparam logic [5:0] SECS_PER_MIN  = 6'd60;
    localparam logic [8:0] DAYS_PER_YEAR = 9'd365;

    // Legal decoded ranges
    localparam logic [7:0] YEAR_MAX  = 8'd99;
    localparam logic [7:0] MONTH_MAX = 8'd12;
    localparam logic [7:0] DAY_MAX   = 8'd31;
    localparam logic [7:0] HOUR_MAX  = 8'd23;
    localparam logic [7:0] MINSEC_MAX = 8'd59;

    // Month codes
    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_MAR = 4'd3;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_MAY = 4'd5;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_JUL = 4'd7;
    localparam logic [3:0] MON_AUG = 4'd8;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_OCT = 4'd10;
    localparam logic [3:0] MON_NOV = 4'd11;
    localparam logic [3:0] MON_DEC = 4'd12;

    // Decoded fields after the first stage
    typedef struct packed {
        logic [7:0] sec;
        logic [7:0] minute;
        logic [7:0] hr;
        logic [7:0] day;
        logic [7:0] mon;
        logic [7:0] yr;
        logic       bad;
    } t_fields;

    // Day count plus time of day after the second stage
    typedef struct packed {
        logic [15:0] days;
        logic [4:0]  hr;
        logic [5:0]  minute;
        logic [5:0]  sec;
        logic        bad;
    } t_days;

    // Packed BCD byte to binary, high nibble * 10 + low nibble (max 165)
    function automatic logic [7:0] bcd_decode(input logic [7:0] b);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = {4'd0, b[7:4]};
        lo = {4'd0, b[3:0]};
        return hi * BCD_RADIX + lo;
    endfunction

    // Days before the first of the month
    function automatic logic [8:0] days_before_month(input logic [3:0] mon,
                                                     input logic       leap);
        logic [8:0] d;
        logic [8:0] adj;
        adj = {8'd0, leap};
        case (mon)
            MON_JAN: d = 9'd0;
            MON_FEB: d = 9'd31;
            MON_MAR: d = 9'd59 + adj;
            MON_APR: d = 9'd90 + adj;
            MON_MAY: d = 9'd120 + adj;
            MON_JUN: d = 9'd151 + adj;
            MON_JUL: d = 9'd181 + adj;
            MON_AUG: d = 9'd212 + adj;
            MON_SEP: d = 9'd243 + adj;
            MON_OCT: d = 9'd273 + adj;
            MON_NOV: d = 9'd304 + adj;
            MON_DEC: d = 9'd334 + adj;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

[rtl/core/bdts_decode.sv]
`timescale 1ns / 1ps

module bdts_decode
    import bdts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_second_bcd,
    input  logic [7:0] i_minute_bcd,
    input  logic [7:0] i_hour_bcd,
    input  logic [7:0] i_day_bcd,
    input  logic [7:0] i_month_bcd,
    input  logic [7:0] i_year_bcd,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_fields    o_fields
);

    logic    r_valid;
    t_fields r_fields;
    t_fields n_fields;

    // Decode all six bytes and range check the results
    always_comb begin
        n_fields.sec    = bcd_decode(i_second_bcd);
        n_fields.minute = bcd_decode(i_minute_bcd);
        n_fields.hr     = bcd_decode(i_hour_bcd);
        n_fields.day    = bcd_decode(i_day_bcd);
        n_fields.mon    = bcd_decode(i_month_bcd);
        n_fields.yr     = bcd_decode(i_year_bcd);
        n_fields.bad    = (n_fields.yr > YEAR_MAX) || (n_fields.mon == 8'd0) ||
                          (n_fields.mon > MONTH_MAX) || (n_fields.day == 8'd0) ||
                          (n_fields.day > DAY_MAX) || (n_fields.hr > HOUR_MAX) ||
                          (n_fields.minute > MINSEC_MAX) || (n_fields.sec > MINSEC_MAX);
    end

    // Stage advances when empty or when downstream takes its request
    assign o_in_ready = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_fields <= n_fields;
        end
    end

    assign o_out_valid = r_valid;
    assign o_fields    = r_fields;

endmodule

[rtl/core/bdts_days.sv]
`timescale 1ns / 1ps

module bdts_days
    import bdts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_fields i_fields,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_days   o_days
);

    logic        r_valid;
    t_days       r_days;
    t_days       n_days;
    logic [15:0] year_days;
    logic [8:0]  leap_days;
    logic [8:0]  month_days;
    logic        leap;

    // Days before the year, before the month, and within the month
    always_comb begin
        leap       = (i_fields.yr[1:0] == 2'b00);
        year_days  = 16'(i_fields.yr) * 16'(DAYS_PER_YEAR);
        leap_days  = ({1'b0, i_fields.yr} + 9'd3) >> 2;
        month_days = days_before_month(i_fields.mon[3:0], leap);
        n_days.days   = year_days + 16'(leap_days) + 16'(month_days)
                        + 16'(i_fields.day) - 16'd1;
        n_days.hr     = i_fields.hr[4:0];
        n_days.minute = i_fields.minute[5:0];
        n_days.sec    = i_fields.sec[5:0];
        n_days.bad    = i_fields.bad;
    end

    assign o_in_ready = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_days <= n_days;
        end
    end

    assign o_out_valid = r_valid;
    assign o_days      = r_days;

endmodule

[rtl/core/bdts_time.sv]
`timescale 1ns / 1ps

module bdts_time
    import bdts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_days       i_days,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_elapsed_seconds,
    output logic        o_invalid
);

    // Stage A: hours
    logic        r_a_valid;
    logic [19:0] r_a_hours;
    logic [5:0]  r_a_minute;
    logic [5:0]  r_a_sec;
    logic        r_a_bad;
    logic        a_ready;
    logic [19:0] n_a_hours;

    // Stage B: minutes
    logic        r_b_valid;
    logic [25:0] r_b_mins;
    logic [5:0]  r_b_sec;
    logic        r_b_bad;
    logic        b_ready;
    logic [25:0] n_b_mins;

    // Stage C: seconds, output register
    logic        r_c_valid;
    logic [31:0] r_c_secs;
    logic        r_c_bad;
    logic        c_ready;
    logic [31:0] n_c_secs;

    assign c_ready    = !r_c_valid || i_out_ready;
    assign b_ready    = !r_b_valid || c_ready;
    assign a_ready    = !r_a_valid || b_ready;
    assign o_in_ready = a_ready;

    // days * 24 + hour
    assign n_a_hours = 20'(i_days.days) * 20'(HOURS_PER_DAY) + 20'(i_days.hr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_in_valid) begin
            r_a_hours  <= n_a_hours;
            r_a_minute <= i_days.minute;
            r_a_sec    <= i_days.sec;
            r_a_bad    <= i_days.bad;
        end
    end

    // hours * 60 + minute
    assign n_b_mins = 26'(r_a_hours) * 26'(MINS_PER_HOUR) + 26'(r_a_minute);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_valid) begin
            r_b_mins <= n_b_mins;
            r_b_sec  <= r_a_sec;
            r_b_bad  <= r_a_bad;
        end
    end

    // minutes * 60 + second, forced to zero on a bad request
    assign n_c_secs = r_b_bad ? 32'd0
                    : 32'(r_b_mins) * 32'(SECS_PER_MIN) + 32'(r_b_sec);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_ready) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_ready && r_b_valid) begin
            r_c_secs <= n_c_secs;
            r_c_bad  <= r_b_bad;
        end
    end

    assign o_out_valid       = r_c_valid;
    assign o_elapsed_seconds = r_c_secs;
    assign o_invalid         = r_c_bad;

endmodule

[rtl/core/bcd_datetime_to_seconds_core.sv]
`timescale 1ns / 1ps

// Channel  Direction  Handshake           Payload
// input    in         i_valid / o_stall   i_second_bcd .. i_year_bcd (6 x 8 bit BCD)
// output   out        o_valid / i_stall   o_elapsed_seconds (32), o_invalid (1)
//
// Five register stages: decode, day count, x24, x60, x60. One request
// is taken every cycle while the output is not stalled.
// Synchronous active-low reset clears all stage valid bits; no other setup.
// A stall holds the output register and backs up only full stages, so
// bubbles are squeezed out and no request is lost or repeated.

module bcd_datetime_to_seconds_core
    import bdts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_second_bcd,
    input  logic [7:0]  i_minute_bcd,
    input  logic [7:0]  i_hour_bcd,
    input  logic [7:0]  i_day_bcd,
    input  logic [7:0]  i_month_bcd,
    input  logic [7:0]  i_year_bcd,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_elapsed_seconds,
    output logic        o_invalid
);

    logic    in_ready;
    logic    dec_valid;
    logic    dec_ready;
    t_fields dec_fields;
    logic    day_valid;
    logic    day_ready;
    t_days   day_data;

    assign o_stall = !in_ready;

    // Stage 1: BCD decode and range check
    bdts_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .o_in_ready   (in_ready),
        .i_second_bcd (i_second_bcd),
        .i_minute_bcd (i_minute_bcd),
        .i_hour_bcd   (i_hour_bcd),
        .i_day_bcd    (i_day_bcd),
        .i_month_bcd  (i_month_bcd),
        .i_year_bcd   (i_year_bcd),
        .o_out_valid  (dec_valid),
        .i_out_ready  (dec_ready),
        .o_fields     (dec_fields)
    );

    // Stage 2: day count
    bdts_days u_days (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (dec_valid),
        .o_in_ready  (dec_ready),
        .i_fields    (dec_fields),
        .o_out_valid (day_valid),
        .i_out_ready (day_ready),
        .o_days      (day_data)
    );

    // Stages 3-5: scale to hours, minutes, seconds
    bdts_time u_time (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (day_valid),
        .o_in_ready        (day_ready),
        .i_days            (day_data),
        .o_out_valid       (o_valid),
        .i_out_ready       (!i_stall),
        .o_elapsed_seconds (o_elapsed_seconds),
        .o_invalid         (o_invalid)
    );

endmodule

[rtl/core/bdts_checker.sv]
`timescale 1ns / 1ps

module bdts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_elapsed_seconds,
    input logic        o_invalid
);

    // A flagged request carries a zero count
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_invalid |-> o_elapsed_seconds == 32'd0)
        else $error("invalid request with nonzero seconds");

    // Count never passes the end of 2099
    a_max_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_elapsed_seconds < 32'd3155760000)
        else $error("seconds count out of range");

    // An empty output register never backs up the input
    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output");

    // Reset flushes the output
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_elapsed_seconds)
                               && $stable(o_invalid))
        else $error("stalled result changed");

endmodule

bind bcd_datetime_to_seconds_core bdts_checker u_bdts_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_stall           (o_stall),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_elapsed_seconds (o_elapsed_seconds),
    .o_invalid         (o_invalid)
);
